### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the frame checker.
// Needs nothing else; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// The antecedent at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/lffrx_pkg.sv
// Package of the length-framed Fletcher receive checker.
// Holds the result payload type, event and command codes and register indexes.
// Depends on nothing; used by the result channel interface and the top level.
package lffrx_pkg;

   localparam int HEADER_BYTES_DEFAULT = 10;
   localparam int POSITION_WIDTH = 9;
   localparam int IDLE_WIDTH = 17;

   localparam logic [POSITION_WIDTH-1:0] POS_DESTINATION = 9'd0;
   localparam logic [POSITION_WIDTH-1:0] POS_SOURCE = 9'd1;
   localparam logic [POSITION_WIDTH-1:0] POS_SUBNET = 9'd2;
   localparam logic [POSITION_WIDTH-1:0] POS_MSG_KIND = 9'd7;
   localparam logic [POSITION_WIDTH-1:0] POS_FRAME_SEQ = 9'd8;
   localparam logic [POSITION_WIDTH-1:0] POS_LENGTH = 9'd9;

   localparam logic [7:0] SEED_RESET = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   localparam logic [1:0] EVENT_MID_FRAME = 2'd0;
   localparam logic [1:0] EVENT_GOOD = 2'd1;
   localparam logic [1:0] EVENT_MISMATCH = 2'd2;
   localparam logic [1:0] EVENT_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] data_byte;
      logic [POSITION_WIDTH-1:0] byte_index;
      logic [7:0] payload_length;
      logic [7:0] destination;
      logic [7:0] source;
      logic [7:0] subnet_id;
      logic [7:0] msg_kind;
      logic [7:0] frame_seq;
      logic [15:0] computed_check;
      logic [15:0] received_check;
   } rsp_payload_type;

endpackage

### rtl/core/lffrx_req_if.sv
// Input channel of the frame checker: a received byte or a millisecond tick.
// Depends on nothing.
interface lffrx_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [7:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink (input valid, command, rx_byte, output ready);
endinterface

### rtl/core/lffrx_rsp_if.sv
// Result channel of the frame checker.
// Depends on lffrx_pkg for the payload type.
interface lffrx_rsp_if;
   logic valid;
   logic ready;
   lffrx_pkg::rsp_payload_type payload;

   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

### rtl/core/length_framed_fletcher_rx_checker.sv
// Top level of the length-framed receiver with a seeded Fletcher check.
// Depends on lffrx_pkg, lffrx_req_if, lffrx_rsp_if and assert_macros.svh.
//
// The block takes one transaction per clock cycle while its skid entry is
// empty. Frame state and running sums are updated by two modulo-255 additions
// at acceptance, and the check word is formed from the stored sums on the
// final byte. A result is registered into the output register, or into the
// one skid entry behind it while that is held, so req_bus.ready depends only
// on whether that entry is occupied, and requests are still accepted while
// one result waits to be taken. Ticks that time nothing out give no result.
`include "assert_macros.svh"

module length_framed_fletcher_rx_checker #(
   parameter int HEADER_BYTES = lffrx_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   lffrx_req_if.sink req_bus,
   lffrx_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int PW = lffrx_pkg::POSITION_WIDTH;
   localparam int IW = lffrx_pkg::IDLE_WIDTH;
   localparam logic [PW-1:0] HEADER_END = PW'(HEADER_BYTES);
   localparam logic [IW-1:0] IDLE_MAX = {IW{1'b1}};

   function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
   endfunction

   logic [15:0] timeout_ff;
   logic [7:0] seed_ff;
   logic [PW-1:0] position_ff, position_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_first_ff, sum_first_in;
   logic [7:0] sum_second_ff, sum_second_in;
   logic [IW-1:0] idle_ff, idle_in;
   logic [7:0] destination_ff, source_ff, subnet_ff, msg_kind_ff, frame_seq_ff;
   logic [7:0] check_high_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic skid_valid_ff, skid_valid_in;
   lffrx_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   lffrx_pkg::rsp_payload_type skid_payload_ff, skid_payload_in;

   logic req_fire, rsp_pop, is_tick, timeout_hit;
   logic result_valid;
   lffrx_pkg::rsp_payload_type result;
   logic [IW-1:0] idle_next;
   logic [PW-1:0] body_end;
   logic [7:0] length_now, seed_mod, sf_base, ss_base, sf_new, ss_new, check_hi, check_lo;
   logic [15:0] computed_check, received_check;

   assign req_bus.ready = !skid_valid_ff;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_pop = rsp_valid_ff && rsp_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   always_comb begin
      is_tick = (req_bus.command == lffrx_pkg::CMD_TICK);
      idle_next = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + IW'(1);
      timeout_hit = is_tick && (position_ff != '0) && (idle_next > {1'b0, timeout_ff});
      seed_mod = (seed_ff == 8'hFF) ? 8'd0 : seed_ff;
      sf_base = (position_ff == '0) ? seed_mod : sum_first_ff;
      ss_base = (position_ff == '0) ? 8'd0 : sum_second_ff;
      sf_new = add_mod255(sf_base, req_bus.rx_byte);
      ss_new = add_mod255(ss_base, sf_new);
      check_hi = 8'hFF - add_mod255(sum_first_ff, sum_second_ff);
      check_lo = 8'hFF - add_mod255(sum_first_ff, check_hi);
      computed_check = {check_hi, check_lo};
      received_check = {check_high_ff, req_bus.rx_byte};
      length_now = (position_ff == lffrx_pkg::POS_LENGTH) ? req_bus.rx_byte : length_ff;
      body_end = HEADER_END + {1'b0, length_ff};

      result = '0;
      result_valid = 1'b0;
      position_in = position_ff;
      length_in = length_ff;
      sum_first_in = sum_first_ff;
      sum_second_in = sum_second_ff;
      idle_in = idle_ff;

      if (req_fire) begin
         if (is_tick) begin
            idle_in = idle_next;
            if (timeout_hit) begin
               result_valid = 1'b1;
               result.event_res = lffrx_pkg::EVENT_TIMEOUT;
               result.byte_index = position_ff;
               result.payload_length = length_ff;
               position_in = '0;
               length_in = '0;
            end
         end else begin
            idle_in = '0;
            result_valid = 1'b1;
            result.data_byte = req_bus.rx_byte;
            result.byte_index = position_ff;
            result.payload_length = length_now;
            length_in = length_now;
            if (position_ff < body_end) begin
               result.event_res = lffrx_pkg::EVENT_MID_FRAME;
               sum_first_in = sf_new;
               sum_second_in = ss_new;
               position_in = position_ff + PW'(1);
            end else if (position_ff == body_end) begin
               result.event_res = lffrx_pkg::EVENT_MID_FRAME;
               position_in = position_ff + PW'(1);
            end else begin
               result.event_res = (computed_check == received_check) ?
                  lffrx_pkg::EVENT_GOOD : lffrx_pkg::EVENT_MISMATCH;
               result.destination = destination_ff;
               result.source = source_ff;
               result.subnet_id = subnet_ff;
               result.msg_kind = msg_kind_ff;
               result.frame_seq = frame_seq_ff;
               result.computed_check = computed_check;
               result.received_check = received_check;
               position_in = '0;
               length_in = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      skid_payload_in = skid_payload_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_payload_in = skid_payload_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result_valid) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_payload_in = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_payload_in = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= lffrx_pkg::TIMEOUT_RESET;
         seed_ff <= lffrx_pkg::SEED_RESET;
         position_ff <= '0;
         length_ff <= '0;
         sum_first_ff <= lffrx_pkg::SEED_RESET;
         sum_second_ff <= '0;
         idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               lffrx_pkg::CSR_TIMEOUT: timeout_ff <= csr_write_data;
               lffrx_pkg::CSR_SEED: seed_ff <= csr_write_data[7:0];
               default: seed_ff <= seed_ff;
            endcase
         end
         position_ff <= position_in;
         length_ff <= length_in;
         sum_first_ff <= sum_first_in;
         sum_second_ff <= sum_second_in;
         idle_ff <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      skid_payload_ff <= skid_payload_in;
      if (req_fire && !is_tick) begin
         if (position_ff == lffrx_pkg::POS_DESTINATION) begin
            destination_ff <= req_bus.rx_byte;
         end
         if (position_ff == lffrx_pkg::POS_SOURCE) begin
            source_ff <= req_bus.rx_byte;
         end
         if (position_ff == lffrx_pkg::POS_SUBNET) begin
            subnet_ff <= req_bus.rx_byte;
         end
         if (position_ff == lffrx_pkg::POS_MSG_KIND) begin
            msg_kind_ff <= req_bus.rx_byte;
         end
         if (position_ff == lffrx_pkg::POS_FRAME_SEQ) begin
            frame_seq_ff <= req_bus.rx_byte;
         end
         if (position_ff == body_end) begin
            check_high_ff <= req_bus.rx_byte;
         end
      end
   end

   `ASSERT_ALWAYS(a_skid_behind_output, clock, reset, !skid_valid_ff || rsp_valid_ff)
   `ASSERT_ALWAYS(a_sums_reduced, clock, reset,
      (sum_first_ff != 8'hFF) && (sum_second_ff != 8'hFF))
   `ASSERT_ALWAYS(a_position_bounded, clock, reset, position_ff <= (body_end + PW'(1)))
   `ASSERT_NEXT(a_frame_end_restarts, clock, reset,
      result_valid && (result.event_res != lffrx_pkg::EVENT_MID_FRAME),
      (position_ff == '0) && (length_ff == '0))

endmodule
